@@ rtl/core/wst_pkg.sv @@
package wst_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int STAMP_W    = 32;
	localparam int VEL_W      = 48;
	localparam int CNT_W      = 7;
	localparam int THR_W      = 47;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 47;

	// Dividend is the 33-bit sample difference magnitude with 16 fraction bits below it.
	localparam int DVD_W      = SAMPLE_W + 1 + FRAC_W;
	localparam int DSR_W      = STAMP_W;
	localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILL       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = CFG_IDX_W'(2);

	localparam logic [CNT_W-1:0] RST_WINDOW_LENGTH  = CNT_W'(16);
	localparam logic [CNT_W-1:0] RST_MIN_FILL       = CNT_W'(2);
	localparam logic [THR_W-1:0] RST_FAST_THRESHOLD = THR_W'(65536);

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic        [STAMP_W-1:0]  stamp;
	} wst_in_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] velocity;
		logic signed [VEL_W-1:0] acceleration;
		logic                    fast_move;
		logic        [CNT_W-1:0] fill_count;
	} wst_out_t;

	typedef struct packed {
		logic [STAMP_W-1:0]  stamp;
		logic [SAMPLE_W-1:0] sample;
	} wst_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic             compute;
	} wst_win_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} wst_div_stat_t;

endpackage

@@ rtl/core/wst_divider.sv @@
module wst_divider import wst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_W-1:0]    dividend,
	input  logic [DSR_W-1:0]    divisor,
	output logic [DVD_W-1:0]    quotient,
	output wst_div_stat_t       stat
);

	logic [DVD_W-1:0]     dvd_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSR_W:0]       shifted;
	logic [DSR_W:0]       trial;
	logic                 fits;

	// One quotient bit per cycle: the dividend shifts out at the top while
	// quotient bits shift in at the bottom of the same register.
	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = ~trial[DSR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/core/wst_window.sv @@
module wst_window import wst_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              push,
	input  wst_entry_t        entry,
	input  logic [CNT_W-1:0]  window_length,
	input  logic [CNT_W-1:0]  min_fill,
	output wst_win_stat_t     stat,
	output wst_entry_t        oldest
);

	// The length register is 7 bits wide, so no more than 127 slots are ever used.
	localparam int LEN_CAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
	localparam int PW      = $clog2(LEN_CAP);
	localparam logic [CNT_W-1:0] LEN_CAP_C = CNT_W'(LEN_CAP);

	wst_entry_t       mem [LEN_CAP];
	wst_entry_t       rd_q;
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    old_q;
	logic [CNT_W-1:0] fill_q;
	logic             compute_q;

	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] wp_ext;
	logic [CNT_W-1:0] fill_nx;
	logic [CNT_W-1:0] back;
	logic [CNT_W-1:0] old_nx;
	logic [PW-1:0]    wp_nx;

	always_comb begin
		if (window_length == '0) begin
			len = CNT_W'(1);
		end else if (window_length > LEN_CAP_C) begin
			len = LEN_CAP_C;
		end else begin
			len = window_length;
		end
		wp_ext  = CNT_W'(wp_q);
		fill_nx = (fill_q < len) ? fill_q + CNT_W'(1) : len;
		back    = fill_nx - CNT_W'(1);
		// The oldest held entry sits fill-1 slots behind the one being written.
		if (wp_ext >= back) begin
			old_nx = wp_ext - back;
		end else begin
			old_nx = wp_ext + len - back;
		end
		if (wp_ext + CNT_W'(1) >= len) begin
			wp_nx = '0;
		end else begin
			wp_nx = wp_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			old_q     <= '0;
			fill_q    <= '0;
			compute_q <= 1'b0;
		end else if (clear) begin
			wp_q      <= '0;
			old_q     <= '0;
			fill_q    <= '0;
			compute_q <= 1'b0;
		end else if (push) begin
			wp_q      <= wp_nx;
			old_q     <= old_nx[PW-1:0];
			fill_q    <= fill_nx;
			compute_q <= (fill_nx >= min_fill);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= entry;
		end
		rd_q <= mem[old_q];
	end

	assign stat.fill    = fill_q;
	assign stat.compute = compute_q;
	assign oldest       = rd_q;

endmodule

@@ rtl/core/window_slope_tracker_top.sv @@
// Sliding-window slope tracker for timestamped Q16.16 samples.
// Input channel: in_valid / in_stall with in_data (sample_value, stamp). A request is
// taken on a rising edge with in_valid high and in_stall low. Each request is stored
// in a ring of the last window_length entries and yields exactly one result.
// Output channel: out_valid / out_stall with out_data (velocity, acceleration,
// fast_move, fill_count). A result is held in an output register until taken.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data. Any write, to a
// known index or not, empties the window and zeroes the previous velocity.
// A request passes the ring read (ST_READ), the divider setup (ST_PREP), the bit-serial
// divider (ST_DIV), which produces one of its 49 quotient bits per cycle and raises a
// finish flag, the sign step (ST_SIGN) and the result step (ST_DONE), whose result is
// loaded into the output register. One request is in work at a time and in_stall stays
// high until the block is back in ST_IDLE, so a new request is taken only after the last
// one is through.
// The next request is taken while a finished result still sits in the output register.
// If the receiver stalls, the following result waits in the block and in_stall stays
// high until the output register frees up.
// Reset restores window_length 16, min_fill 2, fast_threshold 65536 and an empty window.
module window_slope_tracker_top import wst_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  wst_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output wst_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SIGN = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  wlen_q;
	logic [CNT_W-1:0]  mfill_q;
	logic [THR_W-1:0]  thr_q;
	wst_entry_t        new_q;
	logic              neg_q;
	logic              dtz_q;
	logic [VEL_W-1:0]  vel_q;
	logic [VEL_W-1:0]  last_vel_q;
	wst_out_t          out_q;
	logic              out_valid_q;

	logic              in_take;
	logic              cfg_take;
	logic              out_free;
	logic              out_load;
	wst_entry_t        entry;
	wst_entry_t        oldest;
	wst_win_stat_t     win_stat;
	wst_div_stat_t     div_stat;
	logic              div_start;
	logic [DVD_W-1:0]  dividend;
	logic [DSR_W-1:0]  dt;
	logic [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0] dmag;
	logic [DVD_W-1:0]  quotient;
	logic              q_ovf;
	logic [VEL_W-1:0]  vel_nx;
	logic [VEL_W:0]    acc_w;
	logic [VEL_W-1:0]  acc_sat;
	logic [VEL_W-1:0]  acc;
	logic [VEL_W-1:0]  mag;
	logic              fast;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_DONE) && out_free;

	assign entry.stamp  = in_data.stamp;
	assign entry.sample = in_data.sample_value;

	wst_window #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (cfg_take),
		.push          (in_take),
		.entry         (entry),
		.window_length (wlen_q),
		.min_fill      (mfill_q),
		.stat          (win_stat),
		.oldest        (oldest)
	);

	always_comb begin
		dt   = new_q.stamp - oldest.stamp;
		diff = {new_q.sample[SAMPLE_W-1], new_q.sample}
			- {oldest.sample[SAMPLE_W-1], oldest.sample};
		dmag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
		dividend = {dmag, {FRAC_W{1'b0}}};
	end

	assign div_start = (state_q == ST_PREP);

	wst_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dt),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_comb begin
		q_ovf = quotient[DVD_W-1] | quotient[VEL_W-1];
		if (!win_stat.compute || dtz_q) begin
			vel_nx = '0;
		end else if (neg_q) begin
			vel_nx = q_ovf ? VEL_MIN : VEL_W'(-quotient[VEL_W-1:0]);
		end else begin
			vel_nx = q_ovf ? VEL_MAX : quotient[VEL_W-1:0];
		end

		acc_w = {vel_q[VEL_W-1], vel_q} - {last_vel_q[VEL_W-1], last_vel_q};
		if (acc_w[VEL_W] != acc_w[VEL_W-1]) begin
			acc_sat = acc_w[VEL_W] ? VEL_MIN : VEL_MAX;
		end else begin
			acc_sat = acc_w[VEL_W-1:0];
		end
		acc = win_stat.compute ? acc_sat : '0;

		mag  = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : vel_q;
		fast = (mag >= {1'b0, thr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= RST_WINDOW_LENGTH;
			mfill_q <= RST_MIN_FILL;
			thr_q   <= RST_FAST_THRESHOLD;
		end else if (cfg_take) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH:  wlen_q  <= cfg_data[CNT_W-1:0];
				CFG_MIN_FILL:       mfill_q <= cfg_data[CNT_W-1:0];
				CFG_FAST_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_vel_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_take) begin
				last_vel_q <= '0;
			end else if (out_load) begin
				last_vel_q <= win_stat.compute ? vel_q : '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			new_q <= entry;
		end
		if (state_q == ST_PREP) begin
			neg_q <= diff[SAMPLE_W];
			dtz_q <= (dt == '0);
		end
		if (state_q == ST_SIGN) begin
			vel_q <= vel_nx;
		end
		if (out_load) begin
			out_q.velocity     <= vel_q;
			out_q.acceleration <= acc;
			out_q.fast_move    <= fast;
			out_q.fill_count   <= win_stat.fill;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ tb/tb_window_slope_tracker_top.sv @@
`timescale 1ns / 1ps

module tb_window_slope_tracker_top;
	import wst_pkg::*;

	localparam int WIN_MAX = 64;
	localparam longint VEL_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VEL_LO = -VEL_HI - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	wst_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	wst_out_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	window_slope_tracker_top #(.WINDOW_MAX(WIN_MAX)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block's registers and window.
	logic [CNT_W-1:0] cfg_window_length;
	logic [CNT_W-1:0] cfg_min_fill;
	logic [THR_W-1:0] cfg_fast_threshold;
	wst_entry_t       ring [WIN_MAX];
	int unsigned      ring_wr_ptr;
	int unsigned      ring_fill;
	longint           prev_velocity;

	wst_out_t    pending_slopes [$];
	int          err_count;
	int          sample_count;
	int          result_count;
	int          write_count;
	bit          quiet;
	logic [31:0] stamp_now;
	logic [31:0] level_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_window();
		ring_wr_ptr   = 0;
		ring_fill     = 0;
		prev_velocity = 0;
	endfunction

	function automatic longint clip48(longint v);
		if (v > VEL_HI)
			return VEL_HI;
		if (v < VEL_LO)
			return VEL_LO;
		return v;
	endfunction

	// Stores one sample in the window and returns the slope result it should produce.
	function automatic wst_out_t predict_slope(wst_in_t s);
		int unsigned       len;
		int unsigned       oldest;
		int unsigned       newest;
		wst_entry_t        eo;
		wst_entry_t        en;
		logic [31:0]       dt;
		longint            diff;
		longint            vel;
		longint            acc;
		longint unsigned   dm;
		longint unsigned   dtu;
		longint unsigned   q;
		longint unsigned   mag;
		wst_out_t          r;
		len = (cfg_window_length == 0) ? 1 :
			((cfg_window_length > WIN_MAX) ? WIN_MAX : cfg_window_length);
		vel = 0;
		acc = 0;
		if (ring_wr_ptr >= len)
			ring_wr_ptr = 0;
		ring[ring_wr_ptr] = '{stamp: s.stamp, sample: s.sample_value};
		ring_wr_ptr = (ring_wr_ptr + 1) % len;
		if (ring_fill < len)
			ring_fill++;
		if (ring_fill < cfg_min_fill) begin
			prev_velocity = 0;
		end else begin
			oldest = (ring_wr_ptr + len - ring_fill) % len;
			newest = (ring_wr_ptr + len - 1) % len;
			eo = ring[oldest];
			en = ring[newest];
			dt = en.stamp - eo.stamp;
			if (dt != 0) begin
				diff = longint'($signed(en.sample)) - longint'($signed(eo.sample));
				dm = (diff < 0) ? -diff : diff;
				dtu = dt;
				q = (dm << 16) / dtu;
				if (diff < 0) begin
					if (q > 64'h0000_8000_0000_0000)
						q = 64'h0000_8000_0000_0000;
					vel = -longint'(q);
				end else begin
					if (q > VEL_HI)
						q = VEL_HI;
					vel = longint'(q);
				end
			end
			acc = clip48(vel - prev_velocity);
			prev_velocity = vel;
		end
		mag = (vel < 0) ? -vel : vel;
		r.velocity     = vel[VEL_W-1:0];
		r.acceleration = acc[VEL_W-1:0];
		r.fast_move    = (mag >= 64'(cfg_fast_threshold));
		r.fill_count   = CNT_W'(ring_fill);
		return r;
	endfunction

	// Offers one request and records its expected result once it is taken.
	task automatic send_sample(input logic [31:0] value, input logic [31:0] tick);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 16)
			gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{sample_value: value, stamp: tick};
		do @(posedge clk); while (!(in_valid && !in_stall));
		pending_slopes.push_back(predict_slope(in_data));
		sample_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_slopes.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WINDOW_LENGTH:  cfg_window_length  = value[CNT_W-1:0];
			CFG_MIN_FILL:       cfg_min_fill       = value[CNT_W-1:0];
			CFG_FAST_THRESHOLD: cfg_fast_threshold = value[THR_W-1:0];
			default: ;
		endcase
		// Every write, known index or not, empties the window.
		clear_window();
		write_count++;
	endtask

	task automatic test_defaults_after_reset();
		send_sample(32'h0001_0000, 32'd100);
		send_sample(32'h0003_0000, 32'd102);
		send_sample(32'hFFFF_0000, 32'd105);
	endtask

	task automatic test_slope_saturation();
		write_register(CFG_WINDOW_LENGTH, 47'd2);
		write_register(CFG_MIN_FILL, 47'd1);
		write_register(CFG_FAST_THRESHOLD, 47'h7FFF_FFFF_FFFF);
		send_sample(32'h7FFF_FFFF, 32'd10);
		send_sample(32'h8000_0000, 32'd11);
		send_sample(32'h7FFF_FFFF, 32'd12);
		send_sample(32'h8000_0000, 32'd13);
	endtask

	task automatic test_zero_tick_and_wrap();
		write_register(CFG_WINDOW_LENGTH, 47'd3);
		write_register(CFG_MIN_FILL, 47'd0);
		write_register(CFG_FAST_THRESHOLD, 47'd0);
		send_sample(32'h0005_0000, 32'hFFFF_FFFF);
		send_sample(32'h0009_0000, 32'hFFFF_FFFF);
		send_sample(32'hFFFD_0000, 32'h0000_0002);
		send_sample(32'h0000_0000, 32'h0000_0002);
	endtask

	task automatic test_single_entry_window();
		write_register(CFG_WINDOW_LENGTH, 47'd0);
		write_register(CFG_MIN_FILL, 47'd1);
		write_register(CFG_FAST_THRESHOLD, 47'd1);
		send_sample(32'h1234_5678, 32'd7);
		send_sample(32'h8765_4321, 32'd9);
	endtask

	task automatic test_min_fill_unreachable();
		int i;
		// Upper data bits are set to show that only the low bits of the length count.
		write_register(CFG_WINDOW_LENGTH, {40'hA5_A5A5_A5A5, 7'd4});
		write_register(CFG_MIN_FILL, 47'd9);
		write_register(CFG_FAST_THRESHOLD, 47'd0);
		for (i = 0; i < 5; i++)
			send_sample(32'(i) << 20, 32'(i * 3 + 1));
	endtask

	task automatic test_unknown_index_clears();
		write_register(CFG_WINDOW_LENGTH, 47'd8);
		write_register(CFG_MIN_FILL, 47'd2);
		write_register(CFG_FAST_THRESHOLD, 47'd1000);
		send_sample(32'h0000_1000, 32'd50);
		send_sample(32'h0004_0000, 32'd60);
		write_register(CFG_IDX_W'(3), 47'h1234);
		send_sample(32'h0008_0000, 32'd70);
		send_sample(32'hFFF0_0000, 32'd75);
		write_register({CFG_IDX_W{1'b1}}, {CFG_DATA_W{1'b1}});
		send_sample(32'h0000_0001, 32'd80);
	endtask

	task automatic pick_setup();
		logic [CNT_W-1:0]      len;
		logic [CNT_W-1:0]      mf;
		logic [CFG_DATA_W-1:0] word;
		logic [THR_W-1:0]      thr;
		int                    len_eff;
		int                    r;
		int                    order;
		int                    k;
		r = $urandom_range(99);
		if (r < 15)
			len = 0;
		else if (r < 30)
			len = 1;
		else if (r < 40)
			len = 2;
		else if (r < 55)
			len = 64;
		else if (r < 65)
			len = CNT_W'($urandom_range(65, 127));
		else
			len = CNT_W'($urandom_range(3, 63));
		len_eff = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
		word = CFG_DATA_W'({$urandom(), $urandom()});
		if ($urandom_range(1))
			word[CNT_W-1:0] = len;
		else
			word = CFG_DATA_W'(len);
		r = $urandom_range(99);
		if (r < 15)
			mf = 0;
		else if (r < 30)
			mf = 1;
		else if (r < 42)
			mf = CNT_W'($urandom_range(len_eff + 1, 127));
		else if (r < 50)
			mf = 2;
		else
			mf = CNT_W'($urandom_range(0, len_eff));
		r = $urandom_range(99);
		if (r < 12)
			thr = 0;
		else if (r < 24)
			thr = {THR_W{1'b1}};
		else if (r < 40)
			thr = THR_W'({$urandom(), $urandom()});
		else
			thr = (THR_W'(1) << $urandom_range(8, 40)) + THR_W'($urandom_range(0, 65535));
		order = $urandom_range(2);
		for (k = 0; k < 3; k++) begin
			case ((k + order) % 3)
				0: write_register(CFG_WINDOW_LENGTH, word);
				1: write_register(CFG_MIN_FILL, {$urandom(), 8'(mf)} & 47'h7F);
				default: write_register(CFG_FAST_THRESHOLD, thr);
			endcase
		end
		if ($urandom_range(9) == 0)
			write_register(CFG_IDX_W'($urandom_range(3, 255)),
				CFG_DATA_W'({$urandom(), $urandom()}));
	endtask

	task automatic send_random_sample();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			stamp_now += $urandom_range(1, 1000);
		else if (r >= 80 && r < 90)
			stamp_now = $urandom();
		else if (r >= 90)
			stamp_now -= $urandom_range(1, 50);
		r = $urandom_range(99);
		if (r < 60) begin
			level_now += $urandom_range(0, 1 << 20) - (1 << 19);
		end else if (r < 75) begin
			level_now = $urandom();
		end else if (r < 85) begin
			case ($urandom_range(3))
				0: level_now = 32'h7FFF_FFFF;
				1: level_now = 32'h8000_0000;
				2: level_now = 32'h0000_0000;
				default: level_now = 32'hFFFF_FFFF;
			endcase
		end else begin
			level_now += $urandom();
		end
		send_sample(level_now, stamp_now);
	endtask

	task automatic test_random_traffic();
		int p;
		int i;
		for (p = 0; p < 14; p++) begin
			quiet = (p == 6);
			pick_setup();
			for (i = 0; i < 125; i++) begin
				// Hold off the sender once until the block has delivered everything.
				if (p == 3 && i == 60)
					wait_drained();
				send_random_sample();
			end
		end
		quiet = 1'b0;
	endtask

	initial begin : result_monitor
		wst_out_t want;
		wst_out_t got;
		int       stall_left;
		int       r;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = out_data;
				if (pending_slopes.size() == 0) begin
					$error("unexpected result: velocity %0d fill_count %0d",
						got.velocity, got.fill_count);
					err_count++;
				end else begin
					want = pending_slopes.pop_front();
					result_count++;
					if (got.velocity !== want.velocity) begin
						$error("velocity: expected %0d, actual %0d",
							want.velocity, got.velocity);
						err_count++;
					end
					if (got.acceleration !== want.acceleration) begin
						$error("acceleration: expected %0d, actual %0d",
							want.acceleration, got.acceleration);
						err_count++;
					end
					if (got.fast_move !== want.fast_move) begin
						$error("fast_move: expected %0b, actual %0b",
							want.fast_move, got.fast_move);
						err_count++;
					end
					if (got.fill_count !== want.fill_count) begin
						$error("fill_count: expected %0d, actual %0d",
							want.fill_count, got.fill_count);
						err_count++;
					end
				end
			end
			// Mostly single-cycle stalls, now and then one long enough to back up a result.
			if (stall_left == 0 && !quiet) begin
				r = $urandom_range(999);
				if (r < 1)
					stall_left = $urandom_range(60, 150);
				else if (r < 120)
					stall_left = 1;
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		cfg_window_length  = RST_WINDOW_LENGTH;
		cfg_min_fill       = RST_MIN_FILL;
		cfg_fast_threshold = RST_FAST_THRESHOLD;
		clear_window();
		err_count    = 0;
		sample_count = 0;
		result_count = 0;
		write_count  = 0;
		quiet        = 1'b0;
		stamp_now    = $urandom();
		level_now    = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_after_reset();
		test_slope_saturation();
		test_zero_tick_and_wrap();
		test_single_entry_window();
		test_min_fill_unreachable();
		test_unknown_index_clears();
		test_random_traffic();

		wait_drained();
		repeat (80) @(posedge clk);
		$display("Sent %0d samples, checked %0d results, made %0d register writes.",
			sample_count, result_count, write_count);
		$display("Covered clamped and single-entry windows, unreachable fill levels, %s",
			"repeated and wrapped ticks, and saturated slopes under random stalls.");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20_000_000;
		$error("timeout with %0d results still expected", pending_slopes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ window_slope_tracker_top.f @@
rtl/core/wst_pkg.sv
rtl/core/wst_divider.sv
rtl/core/wst_window.sv
rtl/core/window_slope_tracker_top.sv
tb/tb_window_slope_tracker_top.sv
